### rtl/mfdu_pkg.sv
// Package for the motor feedback decoder: field widths, default slot count
// and the constants of the unwrapping and code-centering arithmetic.
// No dependencies.
`default_nettype none

package mfdu_pkg;

    localparam int NUM_MOTORS_DEFAULT = 16;

    localparam int SLOT_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int OFFSET_W = 17;
    localparam int ANGLE_W  = 18;
    localparam int TURN_W   = 16;
    localparam int MULTI_W  = 33;
    localparam int CODE_W   = 12;
    localparam int VALUE_W  = 13;
    localparam int POWER_W  = 24;
    localparam int DIFF_W   = ANGLE_W + 1;

    localparam logic [VALUE_W-1:0] CODE12_MAX = VALUE_W'(4095);
    localparam logic signed [DIFF_W-1:0] HALF_SPAN_CEIL = DIFF_W'(32768);

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [TURN_W-1:0] turn_t;

    typedef struct packed {
        angle_t last_angle;
        turn_t  turn_count;
    } slot_entry_t;

endpackage

`default_nettype wire

### rtl/mfdu_frame_if.sv
// Channel interface that carries one motor feedback frame per beat.
// Depends on mfdu_pkg for the field widths.
`default_nettype none

interface mfdu_frame_if;
    logic                              valid;
    logic                              ready;
    logic [mfdu_pkg::SLOT_W-1:0]       motor_slot;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte0;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte1;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte2;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte3;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte4;
    logic [mfdu_pkg::BYTE_W-1:0]       frame_byte5;

    modport source (
        output valid, motor_slot, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5,
        input  ready
    );

    modport sink (
        input  valid, motor_slot, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mfdu_result_if.sv
// Channel interface that carries one decoded feedback result per beat.
// Depends on mfdu_pkg for the field widths.
`default_nettype none

interface mfdu_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [mfdu_pkg::SLOT_W-1:0]           slot_out;
    logic [mfdu_pkg::STATUS_W-1:0]         motor_status;
    logic signed [mfdu_pkg::ANGLE_W-1:0]   single_angle;
    logic signed [mfdu_pkg::TURN_W-1:0]    turns;
    logic signed [mfdu_pkg::MULTI_W-1:0]   multi_position;
    logic signed [mfdu_pkg::VALUE_W-1:0]   speed_value;
    logic signed [mfdu_pkg::VALUE_W-1:0]   torque_value;
    logic [mfdu_pkg::POWER_W-1:0]          power_value;

    modport source (
        output valid, slot_out, motor_status, single_angle, turns, multi_position,
               speed_value, torque_value, power_value,
        input  ready
    );

    modport sink (
        input  valid, slot_out, motor_status, single_angle, turns, multi_position,
               speed_value, torque_value, power_value,
        output ready
    );
endinterface

`default_nettype wire

### rtl/motor_feedback_decode_unwrap_top.sv
// Motor feedback decoder with per-slot multi-turn unwrapping.
// Depends on mfdu_pkg, mfdu_frame_if and mfdu_result_if.
// Frames pass through decode and result stage registers; one frame per cycle unless
// result.ready stalls. Slot state is read on accept and written as the frame leaves
// the decode stage, with a bypass when consecutive frames share a slot.
// Reset clears the zero offset, the valids and the first-frame flags, not the memory.
`default_nettype none

module motor_feedback_decode_unwrap_top #(
    parameter int NUM_MOTORS = mfdu_pkg::NUM_MOTORS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mfdu_frame_if.sink                               frame,
    mfdu_result_if.source                            result,
    input  wire logic                                cfg_we,
    input  wire logic [mfdu_pkg::OFFSET_W-1:0]       cfg_wdata
);

    localparam int AddrW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Configuration.
    logic signed [mfdu_pkg::OFFSET_W-1:0] zero_offset_reg;

    // Decode stage.
    logic                                   valid1_reg;
    logic [mfdu_pkg::SLOT_W-1:0]            slot1_reg;
    logic [AddrW-1:0]                       addr1_reg;
    logic                                   range1_reg;
    logic [mfdu_pkg::STATUS_W-1:0]          status1_reg;
    mfdu_pkg::angle_t                       angle1_reg;
    logic signed [mfdu_pkg::VALUE_W-1:0]    speed1_reg;
    logic signed [mfdu_pkg::VALUE_W-1:0]    torque1_reg;
    logic [mfdu_pkg::CODE_W-1:0]            spd_abs1_reg;
    logic [mfdu_pkg::CODE_W-1:0]            trq_abs1_reg;

    // Result stage.
    logic                                   valid2_reg;
    logic [mfdu_pkg::SLOT_W-1:0]            slot2_reg;
    logic                                   range2_reg;
    logic [mfdu_pkg::STATUS_W-1:0]          status2_reg;
    mfdu_pkg::angle_t                       angle2_reg;
    mfdu_pkg::turn_t                        turns2_reg;
    logic signed [mfdu_pkg::VALUE_W-1:0]    speed2_reg;
    logic signed [mfdu_pkg::VALUE_W-1:0]    torque2_reg;
    logic [mfdu_pkg::POWER_W-1:0]           power2_reg;

    // Slot state.
    mfdu_pkg::slot_entry_t                  mem [NUM_MOTORS];
    mfdu_pkg::slot_entry_t                  rd_data_reg;
    logic [NUM_MOTORS-1:0]                  seen_reg;

    logic                                   accept;
    logic                                   advance1;
    logic [AddrW+mfdu_pkg::SLOT_W-1:0]      slot_wide;
    logic [AddrW-1:0]                       rd_addr;
    logic                                   in_range0;
    logic [15:0]                            pos_code;
    logic [mfdu_pkg::CODE_W-1:0]            spd_code;
    logic [mfdu_pkg::CODE_W-1:0]            trq_code;
    mfdu_pkg::angle_t                       angle0;

    logic                                   seen1;
    mfdu_pkg::turn_t                        turn_base;
    logic signed [mfdu_pkg::DIFF_W-1:0]     diff;
    logic                                   turn_dec;
    logic                                   turn_inc;
    mfdu_pkg::turn_t                        turn_next;
    logic                                   wr_en;
    mfdu_pkg::slot_entry_t                  wr_data;
    logic signed [mfdu_pkg::MULTI_W-1:0]    turns_wide;

    assign advance1     = valid1_reg && (!valid2_reg || result.ready);
    assign frame.ready  = !valid1_reg || advance1;
    assign accept       = frame.valid && frame.ready;

    assign slot_wide    = {{AddrW{1'b0}}, frame.motor_slot};
    assign rd_addr      = slot_wide[AddrW-1:0];
    assign in_range0    = 32'(frame.motor_slot) < NUM_MOTORS;

    assign pos_code     = {frame.frame_byte1, frame.frame_byte2};
    assign spd_code     = {frame.frame_byte3, frame.frame_byte4[7:4]};
    assign trq_code     = {frame.frame_byte4[3:0], frame.frame_byte5};
    assign angle0       = mfdu_pkg::ANGLE_W'($signed({2'b00, pos_code}))
                          + mfdu_pkg::ANGLE_W'(zero_offset_reg);

    assign seen1        = range1_reg && seen_reg[addr1_reg];
    assign turn_base    = seen1 ? rd_data_reg.turn_count : '0;
    assign diff         = mfdu_pkg::DIFF_W'(angle1_reg) - mfdu_pkg::DIFF_W'(rd_data_reg.last_angle);
    assign turn_dec     = seen1 && (diff >= mfdu_pkg::HALF_SPAN_CEIL);
    assign turn_inc     = seen1 && (diff <= -mfdu_pkg::HALF_SPAN_CEIL);

    always_comb
    begin
        priority if (turn_dec)
        begin
            turn_next = turn_base - mfdu_pkg::TURN_W'(1);
        end
        else if (turn_inc)
        begin
            turn_next = turn_base + mfdu_pkg::TURN_W'(1);
        end
        else
        begin
            turn_next = turn_base;
        end
    end

    assign wr_en                = advance1 && range1_reg;
    assign wr_data.last_angle   = angle1_reg;
    assign wr_data.turn_count   = turn_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            zero_offset_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr1_reg] <= wr_data;
        end
        if (accept)
        begin
            if (wr_en && (addr1_reg == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                seen_reg[addr1_reg] <= 1'b1;
            end
            if (frame.ready)
            begin
                valid1_reg <= frame.valid;
            end
            if (advance1)
            begin
                valid2_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot1_reg    <= frame.motor_slot;
            addr1_reg    <= rd_addr;
            range1_reg   <= in_range0;
            status1_reg  <= frame.frame_byte0[7:4];
            angle1_reg   <= angle0;
            speed1_reg   <= $signed(mfdu_pkg::VALUE_W'({spd_code, 1'b0}) - mfdu_pkg::CODE12_MAX);
            torque1_reg  <= $signed(mfdu_pkg::VALUE_W'({trq_code, 1'b0}) - mfdu_pkg::CODE12_MAX);
            spd_abs1_reg <= {(spd_code[11] ? spd_code[10:0] : ~spd_code[10:0]), 1'b1};
            trq_abs1_reg <= {(trq_code[11] ? trq_code[10:0] : ~trq_code[10:0]), 1'b1};
        end
        if (advance1)
        begin
            slot2_reg   <= slot1_reg;
            range2_reg  <= range1_reg;
            status2_reg <= status1_reg;
            angle2_reg  <= angle1_reg;
            turns2_reg  <= range1_reg ? turn_next : '0;
            speed2_reg  <= speed1_reg;
            torque2_reg <= torque1_reg;
            power2_reg  <= spd_abs1_reg * trq_abs1_reg;
        end
    end

    assign turns_wide = mfdu_pkg::MULTI_W'($signed(turns2_reg));

    assign result.valid          = valid2_reg;
    assign result.slot_out       = slot2_reg;
    assign result.motor_status   = status2_reg;
    assign result.single_angle   = angle2_reg;
    assign result.turns          = $signed(turns2_reg);
    assign result.multi_position = mfdu_pkg::MULTI_W'(angle2_reg)
                                   + (turns_wide <<< 16) - turns_wide;
    assign result.speed_value    = speed2_reg;
    assign result.torque_value   = torque2_reg;
    assign result.power_value    = power2_reg;

    property p_seen_after_write;
        @(posedge clk) disable iff (!rst_n)
        wr_en |=> seen_reg[$past(addr1_reg)];
    endproperty
    a_seen_after_write: assert property (p_seen_after_write)
        else $error("Slot not marked as seen after its state write.");

    property p_out_of_range_turns;
        @(posedge clk) disable iff (!rst_n)
        (valid2_reg && !range2_reg) |-> (turns2_reg == '0);
    endproperty
    a_out_of_range_turns: assert property (p_out_of_range_turns)
        else $error("Out-of-range slot reported a nonzero turn count.");

    property p_power_nonzero;
        @(posedge clk) disable iff (!rst_n)
        valid2_reg |-> (power2_reg != '0);
    endproperty
    a_power_nonzero: assert property (p_power_nonzero)
        else $error("Power of odd speed and torque values came out zero.");

    property p_turn_step_one;
        @(posedge clk) disable iff (!rst_n)
        wr_en |-> ((turn_next == turn_base)
                   || (turn_next == turn_base + mfdu_pkg::TURN_W'(1))
                   || (turn_next == turn_base - mfdu_pkg::TURN_W'(1)));
    endproperty
    a_turn_step_one: assert property (p_turn_step_one)
        else $error("Turn count moved by more than one in a single frame.");

    property p_hold_when_blocked;
        @(posedge clk) disable iff (!rst_n)
        (valid1_reg && !advance1) |-> !frame.ready;
    endproperty
    a_hold_when_blocked: assert property (p_hold_when_blocked)
        else $error("Frame beat accepted while the decode stage was blocked.");

endmodule

`default_nettype wire
